>>> rtl/nmps_pkg.sv
package nmps_pkg;

  // Fixed-point format of unit vectors and shading factors
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int C05       = (5 * ONE + 50) / 100;
  localparam int C95       = (95 * ONE + 50) / 100;
  localparam int S_LIMIT   = (3 * ONE) / 2;
  localparam int LIGHT_Z   = -200;
  localparam int LZ2       = LIGHT_Z * LIGHT_Z;
  localparam int POW_STEPS = 16;
  localparam int SPEC_SHIFT = 9;

  // Field widths
  localparam int PIX_W      = 9;
  localparam int CH_W       = 8;
  localparam int LPOS_W     = 12;
  localparam int VIEW_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int D_W    = LPOS_W + 1;             // light minus pixel
  localparam int AMAG_W = D_W - 1;                // magnitude of a delta
  localparam int SQ_W   = 2 * AMAG_W;
  localparam int SS_W   = SQ_W + 1;               // squared length
  localparam int RW     = SS_W + 2 * FRAC_BITS;   // scaled square / remainder
  localparam int QW     = FRAC_BITS + 1;          // unit magnitude, up to ONE
  localparam int MW     = SS_W + QW;              // root times squared length
  localparam int N_W    = CH_W + 1;
  localparam int L_W    = QW + 1;
  localparam int H_W    = ((L_W > VIEW_W) ? L_W : VIEW_W) + 1;
  localparam int KP_W   = L_W + N_W;
  localparam int HP_W   = H_W + N_W;
  localparam int KR_W   = KP_W + 2;
  localparam int SD_W   = HP_W + 2;
  localparam int S_W    = FRAC_BITS + 2;
  localparam int P_W    = FRAC_BITS + 11;
  localparam int PR_W   = P_W + S_W;
  localparam int KQ_W   = QW;
  localparam int KD_W   = QW;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X = 3'd0,
    CFG_LIGHT_Y = 3'd1,
    CFG_VIEW_X  = 3'd2,
    CFG_VIEW_Y  = 3'd3,
    CFG_VIEW_Z  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [LPOS_W-1:0] light_x;
    logic signed [LPOS_W-1:0] light_y;
    logic signed [VIEW_W-1:0] view_x;
    logic signed [VIEW_W-1:0] view_y;
    logic signed [VIEW_W-1:0] view_z;
  } cfg_regs_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
    logic [CH_W-1:0]  normal_r;
    logic [CH_W-1:0]  normal_g;
    logic [CH_W-1:0]  normal_b;
    rgb_t             color;
  } pix_in_t;

  typedef struct packed {
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nz;
    rgb_t                  color;
  } side_t;

  typedef struct packed {
    logic [RW-1:0]   ax;
    logic [RW-1:0]   ay;
    logic [RW-1:0]   az;
    logic [SS_W-1:0] ss;
    logic            neg_x;
    logic            neg_y;
    side_t           side;
  } front_t;

  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [QW-1:0] qz;
    logic          neg_x;
    logic          neg_y;
    side_t         side;
  } unit_t;

  typedef struct packed {
    logic [KQ_W-1:0]       kq;
    logic signed [P_W-1:0] p;
    rgb_t                  color;
  } light_t;

endpackage

>>> rtl/nmps_if.sv
interface nmps_pix_in_if import nmps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;
  logic [CH_W-1:0]  normal_r;
  logic [CH_W-1:0]  normal_g;
  logic [CH_W-1:0]  normal_b;
  logic [CH_W-1:0]  color_r;
  logic [CH_W-1:0]  color_g;
  logic [CH_W-1:0]  color_b;

  modport source (output valid, pix_x, pix_y, normal_r, normal_g, normal_b,
                  color_r, color_g, color_b, input ready);
  modport sink (input valid, pix_x, pix_y, normal_r, normal_g, normal_b,
                color_r, color_g, color_b, output ready);
endinterface

interface nmps_pix_out_if import nmps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_r;
  logic [CH_W-1:0] out_g;
  logic [CH_W-1:0] out_b;

  modport source (output valid, out_r, out_g, out_b, input ready);
  modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

interface nmps_cfg_if import nmps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/nmps_front.sv
module nmps_front import nmps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  pix_in_t   pix_i,
  input  cfg_regs_t cfg_i,
  output logic      valid_o,
  output front_t    data_o
);

  logic [2:0] v_q;

  logic signed [D_W-1:0] dx_d, dy_d, dx_q, dy_q;
  side_t                 side_d, side1_q, side2_q;
  logic [AMAG_W-1:0]     ax, ay;
  logic [SQ_W-1:0]       sqx_d, sqy_d, sqx_q, sqy_q;
  logic                  negx_q, negy_q;
  front_t                front_d, front_q;

  always_comb begin
    // light minus pixel, normal decode
    dx_d = D_W'($signed(cfg_i.light_x)) - D_W'($signed({1'b0, pix_i.pix_x}));
    dy_d = D_W'($signed(cfg_i.light_y)) - D_W'($signed({1'b0, pix_i.pix_y}));
    side_d.nx    = $signed({1'b0, pix_i.normal_r}) - N_W'(128);
    side_d.ny    = $signed({1'b0, pix_i.normal_g}) - N_W'(128);
    side_d.nz    = -$signed({1'b0, pix_i.normal_b});
    side_d.color = pix_i.color;

    // squares of the magnitudes
    ax    = dx_q[D_W-1] ? AMAG_W'(-dx_q) : AMAG_W'(dx_q);
    ay    = dy_q[D_W-1] ? AMAG_W'(-dy_q) : AMAG_W'(dy_q);
    sqx_d = SQ_W'(ax) * SQ_W'(ax);
    sqy_d = SQ_W'(ay) * SQ_W'(ay);

    // squared length and scaled squares
    front_d.ss    = SS_W'(sqx_q) + SS_W'(sqy_q) + SS_W'(LZ2);
    front_d.ax    = RW'(sqx_q) << (2 * FRAC_BITS);
    front_d.ay    = RW'(sqy_q) << (2 * FRAC_BITS);
    front_d.az    = RW'(LZ2) << (2 * FRAC_BITS);
    front_d.neg_x = negx_q;
    front_d.neg_y = negy_q;
    front_d.side  = side2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      side1_q <= side_d;
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      negx_q  <= dx_q[D_W-1];
      negy_q  <= dy_q[D_W-1];
      side2_q <= side1_q;
      front_q <= front_d;
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = front_q;

endmodule

>>> rtl/nmps_norm.sv
module nmps_norm import nmps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  front_t data_i,
  output logic   valid_o,
  output unit_t  data_o
);

  // One result bit per stage: largest q with q*q*ss <= a*a << 2F,
  // tracking the remainder and q*ss so each stage is shift and add only.
  localparam int NSTG = QW;
  localparam int DW   = RW + 2;

  logic [NSTG-1:0] v_q;

  logic [RW-1:0]   r_q [NSTG][3];
  logic [RW-1:0]   r_d [NSTG][3];
  logic [MW-1:0]   m_q [NSTG][3];
  logic [MW-1:0]   m_d [NSTG][3];
  logic [QW-1:0]   q_q [NSTG][3];
  logic [QW-1:0]   q_d [NSTG][3];
  logic [SS_W-1:0] ss_q [NSTG];
  logic [1:0]      neg_q [NSTG];
  side_t           side_q [NSTG];

  logic [RW-1:0]   r_src;
  logic [MW-1:0]   m_src;
  logic [QW-1:0]   q_src;
  logic [SS_W-1:0] ss_src;
  logic [DW-1:0]   dv;
  logic [RW-1:0]   a_in [3];

  always_comb begin
    a_in[0] = data_i.ax;
    a_in[1] = data_i.ay;
    a_in[2] = data_i.az;
    r_src   = '0;
    m_src   = '0;
    q_src   = '0;
    ss_src  = '0;
    dv      = '0;
    for (int i = 0; i < NSTG; i++) begin
      for (int l = 0; l < 3; l++) begin
        if (i == 0) begin
          r_src  = a_in[l];
          m_src  = '0;
          q_src  = '0;
          ss_src = data_i.ss;
        end else begin
          r_src  = r_q[i-1][l];
          m_src  = m_q[i-1][l];
          q_src  = q_q[i-1][l];
          ss_src = ss_q[i-1];
        end
        dv = (DW'(m_src) << (NSTG - i)) + (DW'(ss_src) << (2 * (NSTG - 1 - i)));
        if (DW'(r_src) >= dv) begin
          r_d[i][l] = RW'(DW'(r_src) - dv);
          m_d[i][l] = m_src + (MW'(ss_src) << (NSTG - 1 - i));
          q_d[i][l] = q_src | (QW'(1) << (NSTG - 1 - i));
        end else begin
          r_d[i][l] = r_src;
          m_d[i][l] = m_src;
          q_d[i][l] = q_src;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NSTG; i++) begin
        r_q[i] <= r_d[i];
        m_q[i] <= m_d[i];
        q_q[i] <= q_d[i];
        if (i == 0) begin
          ss_q[i]   <= data_i.ss;
          neg_q[i]  <= {data_i.neg_y, data_i.neg_x};
          side_q[i] <= data_i.side;
        end else begin
          ss_q[i]   <= ss_q[i-1];
          neg_q[i]  <= neg_q[i-1];
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  always_comb begin
    data_o.qx    = q_q[NSTG-1][0];
    data_o.qy    = q_q[NSTG-1][1];
    data_o.qz    = q_q[NSTG-1][2];
    data_o.neg_x = neg_q[NSTG-1][0];
    data_o.neg_y = neg_q[NSTG-1][1];
    data_o.side  = side_q[NSTG-1];
  end

  assign valid_o = v_q[NSTG-1];

endmodule

>>> rtl/nmps_light.sv
module nmps_light import nmps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  unit_t     data_i,
  input  cfg_regs_t cfg_i,
  output logic      valid_o,
  output light_t    data_o
);

  localparam int NV = POW_STEPS + 2;

  logic [NV-1:0] v_q;

  logic signed [L_W-1:0]  l_v [3];
  logic signed [H_W-1:0]  h_v [3];
  logic signed [N_W-1:0]  n_v [3];
  logic signed [KP_W-1:0] kp_d [3];
  logic signed [KP_W-1:0] kp_q [3];
  logic signed [HP_W-1:0] hp_d [3];
  logic signed [HP_W-1:0] hp_q [3];
  rgb_t                   col_a_q, col_b_q;

  logic signed [KR_W-1:0] kraw;
  logic signed [SD_W-1:0] sd, sdiv;
  logic signed [S_W-1:0]  s_clip, s_d, s_b_q;
  logic signed [P_W-1:0]  p_b_q;
  logic [KQ_W-1:0]        kq_d, kq_b_q;

  logic signed [P_W-1:0]  p_q [POW_STEPS];
  logic signed [P_W-1:0]  p_d [POW_STEPS];
  logic signed [S_W-1:0]  s_q [POW_STEPS];
  logic [KQ_W-1:0]        kq_q [POW_STEPS];
  rgb_t                   col_q [POW_STEPS];
  logic signed [PR_W-1:0] prod;
  logic signed [P_W-1:0]  p_src;
  logic signed [S_W-1:0]  s_src;

  // unit light, half vector, dot product terms
  always_comb begin
    l_v[0] = data_i.neg_x ? -$signed(L_W'(data_i.qx)) : $signed(L_W'(data_i.qx));
    l_v[1] = data_i.neg_y ? -$signed(L_W'(data_i.qy)) : $signed(L_W'(data_i.qy));
    l_v[2] = -$signed(L_W'(data_i.qz));
    h_v[0] = H_W'(l_v[0]) + H_W'(cfg_i.view_x);
    h_v[1] = H_W'(l_v[1]) + H_W'(cfg_i.view_y);
    h_v[2] = H_W'(l_v[2]) + H_W'(cfg_i.view_z);
    n_v[0] = data_i.side.nx;
    n_v[1] = data_i.side.ny;
    n_v[2] = data_i.side.nz;
    for (int l = 0; l < 3; l++) begin
      kp_d[l] = KP_W'(l_v[l]) * KP_W'(n_v[l]);
      hp_d[l] = HP_W'(h_v[l]) * HP_W'(n_v[l]);
    end
  end

  // sums, diffuse clamp, specular base
  always_comb begin
    kraw = KR_W'(kp_q[0]) + KR_W'(kp_q[1]) + KR_W'(kp_q[2]);
    sd   = SD_W'(hp_q[0]) + SD_W'(hp_q[1]) + SD_W'(hp_q[2]);
    // truncate toward zero
    if (sd < 0) begin
      sdiv = (sd + SD_W'((1 << SPEC_SHIFT) - 1)) >>> SPEC_SHIFT;
    end else begin
      sdiv = sd >>> SPEC_SHIFT;
    end
    if (sdiv > SD_W'(S_LIMIT)) begin
      s_clip = S_W'(S_LIMIT);
    end else if (sdiv < SD_W'(-S_LIMIT)) begin
      s_clip = S_W'(-S_LIMIT);
    end else begin
      s_clip = S_W'(sdiv);
    end
    // specular only when the light is in front
    s_d = (kraw > 0) ? s_clip : '0;
    if (kraw <= 0) begin
      kq_d = '0;
    end else if (kraw > KR_W'(ONE << 8)) begin
      kq_d = KQ_W'(ONE);
    end else begin
      kq_d = KQ_W'(kraw >>> 8);
    end
  end

  // one truncating multiply per stage
  always_comb begin
    prod  = '0;
    p_src = '0;
    s_src = '0;
    for (int i = 0; i < POW_STEPS; i++) begin
      if (i == 0) begin
        p_src = p_b_q;
        s_src = s_b_q;
      end else begin
        p_src = p_q[i-1];
        s_src = s_q[i-1];
      end
      prod = PR_W'(p_src) * PR_W'(s_src);
      if (prod < 0) begin
        p_d[i] = P_W'((prod + PR_W'(ONE - 1)) >>> FRAC_BITS);
      end else begin
        p_d[i] = P_W'(prod >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kp_q    <= kp_d;
      hp_q    <= hp_d;
      col_a_q <= data_i.side.color;
      s_b_q   <= s_d;
      p_b_q   <= P_W'(s_d);
      kq_b_q  <= kq_d;
      col_b_q <= col_a_q;
      for (int i = 0; i < POW_STEPS; i++) begin
        p_q[i] <= p_d[i];
        if (i == 0) begin
          s_q[i]   <= s_b_q;
          kq_q[i]  <= kq_b_q;
          col_q[i] <= col_b_q;
        end else begin
          s_q[i]   <= s_q[i-1];
          kq_q[i]  <= kq_q[i-1];
          col_q[i] <= col_q[i-1];
        end
      end
    end
  end

  always_comb begin
    data_o.kq    = kq_q[POW_STEPS-1];
    data_o.p     = p_q[POW_STEPS-1];
    data_o.color = col_q[POW_STEPS-1];
  end

  assign valid_o = v_q[NV-1];

endmodule

>>> rtl/nmps_shade.sv
module nmps_shade import nmps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  light_t data_i,
  output logic   valid_o,
  output rgb_t   data_o
);

  localparam int KQ2_W = 2 * KQ_W;
  localparam int K3_W  = 3 * KQ_W;
  localparam int KDP_W = 2 * KD_W;
  localparam int CK_W  = CH_W + KD_W;
  localparam int OM_W  = P_W + 1;
  localparam int PD_W  = CK_W + OM_W + 2;

  logic [5:0] v_q;

  logic [KQ2_W-1:0]       kq2_q;
  logic [KQ_W-1:0]        kq1_q, k3_d, k3_q;
  logic [KD_W-1:0]        kd_d, kd_q;
  logic signed [P_W-1:0]  p1_q, p2_q, p3_q, p4_q;
  rgb_t                   c1_q, c2_q, c3_q;
  logic [CH_W-1:0]        c_v [3];
  logic [CK_W-1:0]        ck_d [3];
  logic [CK_W-1:0]        ck_q [3];
  logic signed [OM_W-1:0] om_d, om_q;
  logic signed [PD_W-1:0] prod_d [3];
  logic signed [PD_W-1:0] prod_q [3];
  logic signed [PD_W-1:0] spec_d, spec_q, sum_v, sh_v;
  logic [CH_W-1:0]        ch_d [3];
  rgb_t                   out_q;

  always_comb begin
    k3_d = KQ_W'((K3_W'(kq2_q) * K3_W'(kq1_q)) >> (2 * FRAC_BITS));
    kd_d = KD_W'(C05) + KD_W'((KDP_W'(C95) * KDP_W'(k3_q)) >> FRAC_BITS);

    c_v[0] = c3_q.r;
    c_v[1] = c3_q.g;
    c_v[2] = c3_q.b;
    om_d   = OM_W'(ONE) - OM_W'(p3_q);
    spec_d = ((PD_W'(p4_q) <<< 8) - PD_W'(p4_q)) <<< FRAC_BITS;
    sum_v  = '0;
    sh_v   = '0;
    for (int c = 0; c < 3; c++) begin
      ck_d[c]   = CK_W'(c_v[c]) * CK_W'(kd_q);
      prod_d[c] = PD_W'($signed({1'b0, ck_q[c]})) * PD_W'(om_q);
      // saturate the channel
      sum_v = prod_q[c] + spec_q;
      sh_v  = sum_v >>> (2 * FRAC_BITS);
      if (sum_v < 0) begin
        ch_d[c] = '0;
      end else if (sh_v > PD_W'((1 << CH_W) - 1)) begin
        ch_d[c] = '1;
      end else begin
        ch_d[c] = sh_v[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kq2_q  <= KQ2_W'(data_i.kq) * KQ2_W'(data_i.kq);
      kq1_q  <= data_i.kq;
      p1_q   <= data_i.p;
      c1_q   <= data_i.color;
      k3_q   <= k3_d;
      p2_q   <= p1_q;
      c2_q   <= c1_q;
      kd_q   <= kd_d;
      p3_q   <= p2_q;
      c3_q   <= c2_q;
      ck_q   <= ck_d;
      om_q   <= om_d;
      p4_q   <= p3_q;
      prod_q <= prod_d;
      spec_q <= spec_d;
      out_q  <= '{r: ch_d[0], g: ch_d[1], b: ch_d[2]};
    end
  end

  assign valid_o = v_q[5];
  assign data_o  = out_q;

endmodule

>>> rtl/normal_map_pixel_shader_top.sv
// Normal-mapped pixel shader, Blinn-Phong style, fixed point.
// pix_i takes one pixel request: coordinates, a normal-map texel and a color
// texel. pix_o returns one shaded RGB request per input, in input order.
// cfg_i writes the light position and view vector registers; it is always
// ready and writes to an unknown index are dropped. Write it only while no
// pixel is in flight.
// Throughput: one pixel per clock while the skid register is free. Every
// step is its own pipeline stage: three front stages, one stage per result
// bit of the exact normalization (15), two dot-product stages, one stage per
// multiply of the specular power (16) and six shading stages.
// Stall: when pix_o is not ready, a skid register takes the request that
// leaves the pipeline; while it is full the whole pipeline holds and
// pix_i.ready is low. Nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits and loads the register reset values
// (light at 256, 256; view vector 0, 0, -1).
module normal_map_pixel_shader_top import nmps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nmps_pix_in_if.sink           pix_i,
  nmps_pix_out_if.source        pix_o,
  nmps_cfg_if.sink              cfg_i
);

  cfg_regs_t cfg_q;

  pix_in_t in_data;
  logic    en;

  logic    front_valid, norm_valid, light_valid, shade_valid;
  front_t  front_data;
  unit_t   norm_data;
  light_t  light_data;
  rgb_t    shade_data;

  logic    take;
  logic    out_valid_q, skid_valid_q;
  rgb_t    out_data_q, skid_data_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_x <= LPOS_W'(256);
      cfg_q.light_y <= LPOS_W'(256);
      cfg_q.view_x  <= '0;
      cfg_q.view_y  <= '0;
      cfg_q.view_z  <= VIEW_W'(-ONE);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LIGHT_X: cfg_q.light_x <= cfg_i.data[LPOS_W-1:0];
        CFG_LIGHT_Y: cfg_q.light_y <= cfg_i.data[LPOS_W-1:0];
        CFG_VIEW_X:  cfg_q.view_x  <= cfg_i.data[VIEW_W-1:0];
        CFG_VIEW_Y:  cfg_q.view_y  <= cfg_i.data[VIEW_W-1:0];
        CFG_VIEW_Z:  cfg_q.view_z  <= cfg_i.data[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid register is free
  assign en          = !skid_valid_q;
  assign pix_i.ready = en;

  always_comb begin
    in_data.pix_x    = pix_i.pix_x;
    in_data.pix_y    = pix_i.pix_y;
    in_data.normal_r = pix_i.normal_r;
    in_data.normal_g = pix_i.normal_g;
    in_data.normal_b = pix_i.normal_b;
    in_data.color.r  = pix_i.color_r;
    in_data.color.g  = pix_i.color_g;
    in_data.color.b  = pix_i.color_b;
  end

  // Light delta, squares and squared length
  nmps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .pix_i   (in_data),
    .cfg_i   (cfg_q),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  // Exact normalization of the light vector, one bit per stage
  nmps_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (norm_valid),
    .data_o  (norm_data)
  );

  // Diffuse and specular dot products, specular power chain
  nmps_light u_light (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .data_i  (norm_data),
    .cfg_i   (cfg_q),
    .valid_o (light_valid),
    .data_o  (light_data)
  );

  // Diffuse cube, blend and saturation
  nmps_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (light_valid),
    .data_i  (light_data),
    .valid_o (shade_valid),
    .data_o  (shade_data)
  );

  // Output register with skid: a request leaving the pipeline while the
  // output is held goes to the skid register.
  assign take = shade_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pix_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= take;
      end
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pix_o.ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : shade_data;
    end else if (take) begin
      skid_data_q <= shade_data;
    end
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.out_r = out_data_q.r;
  assign pix_o.out_g = out_data_q.g;
  assign pix_o.out_b = out_data_q.b;

endmodule
